// ===== rtl/core/dfp_pkg.sv =====
// ----------------------------------------------------------------------------
// dfp_pkg
// Shared constants for the detection frame parser: register indices, frame
// layout and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package dfp_pkg;

	localparam int CFG_IW = 2;
	localparam int CFG_DW = 11;

	localparam logic [CFG_IW-1:0] CFG_START_BYTE = 2'd0;
	localparam logic [CFG_IW-1:0] CFG_END_BYTE   = 2'd1;
	localparam logic [CFG_IW-1:0] CFG_MAX_LEN    = 2'd2;

	localparam logic [CFG_DW-1:0] MAX_FRAME = 11'd1024;

	localparam logic [7:0]  BOX_TYPE   = 8'd2;
	localparam logic [15:0] HDR_BYTES  = 16'd7;
	localparam logic [15:0] MIN_LEN    = 16'd5;
	localparam logic [16:0] FIXED_NEED = 17'd13;
	localparam logic [16:0] BOX_NEED   = 17'd8;

endpackage

`default_nettype wire

// ===== rtl/core/dfp_ram.sv =====
// ----------------------------------------------------------------------------
// dfp_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module dfp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  wire logic                                          clk,
	input  wire logic                                          we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
	input  wire logic [WIDTH-1:0]                              wdata,
	input  wire logic                                          re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
	output      logic [WIDTH-1:0]                              rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/detection_frame_parser.sv =====
// ----------------------------------------------------------------------------
// detection_frame_parser
// Byte-serial parser for length-prefixed detection frames with XOR checksum.
// ----------------------------------------------------------------------------
// Sequence: after the end byte the label store is read (ST_EMIT_RD) and the
//   first result is then presented (ST_EMIT_OUT); each further result repeats
//   the label store read and the output state, which holds until out_ready.
// Throughput: one byte per cycle while parsing; no byte is taken while a
//   frame's results are being emitted.
// Reset: hunting, start/end byte zero, length limit 1024; label store undefined.
`default_nettype none

module detection_frame_parser #(
	parameter int LABEL_MAX = 32
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output      logic                        in_ready,
	input  wire logic [7:0]                  rx_byte,
	output      logic                        out_valid,
	input  wire logic                        out_ready,
	output      logic [7:0]                  record_type,
	output      logic [15:0]                 object_id,
	output      logic [15:0]                 class_id,
	output      logic [5:0]                  label_length,
	output      logic [7:0]                  label_char,
	output      logic [31:0]                 confidence_bits,
	output      logic [15:0]                 box_x,
	output      logic [15:0]                 box_y,
	output      logic [15:0]                 box_width,
	output      logic [15:0]                 box_height,
	output      logic [7:0]                  frame_checksum,
	output      logic                        last_of_object,
	input  wire logic                        cfg_valid,
	output      logic                        cfg_ready,
	input  wire logic [dfp_pkg::CFG_IW-1:0]  cfg_index,
	input  wire logic [dfp_pkg::CFG_DW-1:0]  cfg_data
);
	import dfp_pkg::*;

	localparam int LAW = (LABEL_MAX > 1) ? $clog2(LABEL_MAX) : 1;

	typedef enum logic [2:0] {
		ST_HUNT,
		ST_LEN_HI,
		ST_LEN_LO,
		ST_BODY,
		ST_EMIT_RD,
		ST_EMIT_OUT
	} state_t;

	state_t      state_q;
	logic [7:0]  start_q;
	logic [7:0]  end_q;
	logic [10:0] maxlen_q;
	logic [7:0]  len_hi_q;
	logic [10:0] body_len_q;
	logic [10:0] pos_q;
	logic [7:0]  xor_q;
	logic [7:0]  rxck_q;
	logic [7:0]  type_q;
	logic [15:0] id_q;
	logic [15:0] class_q;
	logic [15:0] lab_q;
	logic [31:0] conf_q;
	logic [15:0] bx_q;
	logic [15:0] by_q;
	logic [15:0] bw_q;
	logic [15:0] bh_q;
	logic [6:0]  idx_q;

	logic        in_acc;
	logic [15:0] frame_len;
	logic        pos_last;
	logic [15:0] off;
	logic [15:0] kk;
	logic        in_label;
	logic [16:0] need;
	logic        frame_ok;
	logic        is_box;
	logic [6:0]  emit_cnt;
	logic        emit_last;
	logic        ram_we;
	logic [LAW-1:0] ram_waddr;
	logic [LAW-1:0] ram_raddr;
	logic [7:0]  ram_rdata;

	assign in_ready  = (state_q == ST_HUNT) || (state_q == ST_LEN_HI) ||
	                   (state_q == ST_LEN_LO) || (state_q == ST_BODY);
	assign in_acc    = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	assign frame_len = {len_hi_q, rx_byte};
	assign pos_last  = ({1'b0, pos_q} + 12'd1) == {1'b0, body_len_q};
	assign off       = {5'd0, pos_q} - HDR_BYTES;
	assign kk        = off - lab_q;
	assign in_label  = off < lab_q;
	assign is_box    = type_q == BOX_TYPE;
	assign need      = {1'b0, lab_q} + FIXED_NEED + (is_box ? BOX_NEED : 17'd0);
	assign frame_ok  = (rx_byte == end_q) && (xor_q == rxck_q) &&
	                   (lab_q <= 16'(LABEL_MAX)) && ({6'd0, body_len_q} >= need);

	assign emit_cnt  = (lab_q == 16'd0) ? 7'd1 : lab_q[6:0];
	assign emit_last = (idx_q + 7'd1) == emit_cnt;

	assign ram_we    = in_acc && (state_q == ST_BODY) && !pos_last &&
	                   ({5'd0, pos_q} >= HDR_BYTES) && in_label &&
	                   (off < 16'(LABEL_MAX));
	assign ram_waddr = off[LAW-1:0];
	assign ram_raddr = idx_q[LAW-1:0];

	dfp_ram #(
		.WIDTH (8),
		.DEPTH (LABEL_MAX)
	) u_label_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (rx_byte),
		.re    (state_q == ST_EMIT_RD),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_HUNT;
			start_q    <= 8'd0;
			end_q      <= 8'd0;
			maxlen_q   <= MAX_FRAME;
			len_hi_q   <= 8'd0;
			body_len_q <= 11'd0;
			pos_q      <= 11'd0;
			xor_q      <= 8'd0;
			rxck_q     <= 8'd0;
			type_q     <= 8'd0;
			id_q       <= 16'd0;
			class_q    <= 16'd0;
			lab_q      <= 16'd0;
			conf_q     <= 32'd0;
			bx_q       <= 16'd0;
			by_q       <= 16'd0;
			bw_q       <= 16'd0;
			bh_q       <= 16'd0;
			idx_q      <= 7'd0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_START_BYTE: start_q  <= cfg_data[7:0];
					CFG_END_BYTE:   end_q    <= cfg_data[7:0];
					CFG_MAX_LEN:    maxlen_q <= cfg_data;
					default: ;
				endcase
			end
			case (state_q)
				ST_HUNT: begin
					if (in_acc && rx_byte == start_q) begin
						xor_q   <= rx_byte;
						type_q  <= 8'd0;
						id_q    <= 16'd0;
						class_q <= 16'd0;
						lab_q   <= 16'd0;
						conf_q  <= 32'd0;
						bx_q    <= 16'd0;
						by_q    <= 16'd0;
						bw_q    <= 16'd0;
						bh_q    <= 16'd0;
						state_q <= ST_LEN_HI;
					end
				end
				ST_LEN_HI: begin
					if (in_acc) begin
						len_hi_q <= rx_byte;
						xor_q    <= xor_q ^ rx_byte;
						state_q  <= ST_LEN_LO;
					end
				end
				ST_LEN_LO: begin
					if (in_acc) begin
						xor_q      <= xor_q ^ rx_byte;
						pos_q      <= 11'd0;
						rxck_q     <= 8'd0;
						body_len_q <= frame_len[10:0] - 11'd3;
						if (frame_len > {5'd0, maxlen_q} || frame_len < MIN_LEN) begin
							state_q <= ST_HUNT;
						end else begin
							state_q <= ST_BODY;
						end
					end
				end
				ST_BODY: begin
					if (in_acc) begin
						if (pos_last) begin
							idx_q   <= 7'd0;
							state_q <= frame_ok ? ST_EMIT_RD : ST_HUNT;
						end else begin
							if (pos_q != 11'd0) begin
								xor_q <= xor_q ^ rxck_q;
							end
							rxck_q <= rx_byte;
							pos_q  <= pos_q + 11'd1;
							case (pos_q)
								11'd0: type_q        <= rx_byte;
								11'd1: id_q[15:8]    <= rx_byte;
								11'd2: id_q[7:0]     <= rx_byte;
								11'd3: class_q[15:8] <= rx_byte;
								11'd4: class_q[7:0]  <= rx_byte;
								11'd5: lab_q[15:8]   <= rx_byte;
								11'd6: lab_q[7:0]    <= rx_byte;
								default: begin
									if (!in_label && kk < 16'd12) begin
										case (kk[3:0])
											4'd0:  conf_q[7:0]   <= rx_byte;
											4'd1:  conf_q[15:8]  <= rx_byte;
											4'd2:  conf_q[23:16] <= rx_byte;
											4'd3:  conf_q[31:24] <= rx_byte;
											4'd4:  bx_q[15:8]    <= rx_byte;
											4'd5:  bx_q[7:0]     <= rx_byte;
											4'd6:  by_q[15:8]    <= rx_byte;
											4'd7:  by_q[7:0]     <= rx_byte;
											4'd8:  bw_q[15:8]    <= rx_byte;
											4'd9:  bw_q[7:0]     <= rx_byte;
											4'd10: bh_q[15:8]    <= rx_byte;
											4'd11: bh_q[7:0]     <= rx_byte;
											default: ;
										endcase
									end
								end
							endcase
						end
					end
				end
				ST_EMIT_RD: begin
					state_q <= ST_EMIT_OUT;
				end
				ST_EMIT_OUT: begin
					if (out_ready) begin
						if (emit_last) begin
							state_q <= ST_HUNT;
						end else begin
							idx_q   <= idx_q + 7'd1;
							state_q <= ST_EMIT_RD;
						end
					end
				end
				default: state_q <= ST_HUNT;
			endcase
		end
	end

	assign out_valid       = state_q == ST_EMIT_OUT;
	assign record_type     = type_q;
	assign object_id       = id_q;
	assign class_id        = class_q;
	assign label_length    = lab_q[5:0];
	assign label_char      = (lab_q == 16'd0) ? 8'd0 : ram_rdata;
	assign confidence_bits = conf_q;
	assign box_x           = is_box ? bx_q : 16'd0;
	assign box_y           = is_box ? by_q : 16'd0;
	assign box_width       = is_box ? bw_q : 16'd0;
	assign box_height      = is_box ? bh_q : 16'd0;
	assign frame_checksum  = xor_q;
	assign last_of_object  = emit_last;

endmodule

`default_nettype wire

// ===== rtl/core/dfp_checker.sv =====
// ----------------------------------------------------------------------------
// dfp_checker
// Port-level checks on the detection frame parser, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module dfp_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        in_ready,
	input wire logic                        out_valid,
	input wire logic                        out_ready,
	input wire logic [7:0]                  record_type,
	input wire logic [5:0]                  label_length,
	input wire logic [7:0]                  label_char,
	input wire logic [15:0]                 box_x,
	input wire logic [15:0]                 box_y,
	input wire logic [15:0]                 box_width,
	input wire logic [15:0]                 box_height,
	input wire logic                        last_of_object
);
	import dfp_pkg::*;

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("byte taken while a result beat is pending");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(label_char) &&
		$stable(last_of_object))
		else $error("result beat changed while stalled");

	a_next_beat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_of_object |=> !out_valid ##1 out_valid)
		else $error("next label beat missing");

	a_empty_label: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && label_length == 6'd0 |-> last_of_object && label_char == 8'd0)
		else $error("empty label must give one zero beat");

	a_no_box: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && record_type != BOX_TYPE |-> box_x == 16'd0 && box_y == 16'd0 &&
		box_width == 16'd0 && box_height == 16'd0)
		else $error("box fields set without a box");

endmodule

bind detection_frame_parser dfp_checker u_dfp_checker (.*);

`default_nettype wire
